@@ hw/rtl/lsm_pkg.sv @@
// Shared types and constants for the latency statistics monitor.
// Used by lsm_mem, lsm_div and latency_stats_monitor; depends on nothing.
package lsm_pkg;

    localparam int DATA_W    = 32;
    localparam int TS_W      = 64;
    localparam int OP_W      = 2;
    localparam int REQ_W     = 8;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Operation codes carried in the op field
    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_STOP   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // One statistics record as stored and returned
    typedef struct packed {
        logic [DATA_W-1:0] call_count;
        logic [DATA_W-1:0] total_time;
        logic [DATA_W-1:0] last_time;
        logic [DATA_W-1:0] min_time;
        logic [DATA_W-1:0] max_time;
        logic [DATA_W-1:0] mean_time;
    } rec_t;

    // Write and clear commands from the controller to the record store
    typedef struct packed {
        logic stats_we;
        logic stamp_we;
        logic clr_stats;
        logic clr_stamp;
        logic clr_all;
    } mem_cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_FOLD,
        ST_DIV,
        ST_WB
    } state_t;

endpackage

@@ hw/rtl/lsm_mem.sv @@
// Record store: statistics memory and start-stamp memory, registered read.
// Per-entry valid bits make unwritten or cleared entries read as zero.
// Depends on lsm_pkg.
module lsm_mem #(
    parameter int NUM_INSTANCES = 32,
    parameter int IDX_W         = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    output lsm_pkg::rec_t              stats_rd,
    output logic [lsm_pkg::DATA_W-1:0] stamp_rd,
    input  logic [IDX_W-1:0]           wr_addr,
    input  lsm_pkg::mem_cmd_t          cmd,
    input  lsm_pkg::rec_t              stats_wdata,
    input  logic [lsm_pkg::DATA_W-1:0] stamp_wdata
);
    import lsm_pkg::*;

    rec_t              stats_mem [NUM_INSTANCES];
    logic [DATA_W-1:0] stamp_mem [NUM_INSTANCES];

    rec_t              stats_raw_reg;
    logic [DATA_W-1:0] stamp_raw_reg;
    logic              stats_hit_reg;
    logic              stamp_hit_reg;

    logic [NUM_INSTANCES-1:0] stats_vld_reg;
    logic [NUM_INSTANCES-1:0] stats_vld_next;
    logic [NUM_INSTANCES-1:0] stamp_vld_reg;
    logic [NUM_INSTANCES-1:0] stamp_vld_next;

    // Write and read the arrays
    always_ff @(posedge clk)
    begin
        if (cmd.stats_we)
        begin
            stats_mem[wr_addr] <= stats_wdata;
        end
        if (cmd.stamp_we)
        begin
            stamp_mem[wr_addr] <= stamp_wdata;
        end
        if (rd_en)
        begin
            stats_raw_reg <= stats_mem[rd_addr];
            stamp_raw_reg <= stamp_mem[rd_addr];
        end
    end

    // Update valid bits: set on write, drop on clear
    always_comb
    begin
        stats_vld_next = stats_vld_reg;
        stamp_vld_next = stamp_vld_reg;
        if (cmd.clr_all)
        begin
            stats_vld_next = '0;
            stamp_vld_next = '0;
        end
        else
        begin
            if (cmd.stats_we)
            begin
                stats_vld_next[wr_addr] = 1'b1;
            end
            if (cmd.clr_stats)
            begin
                stats_vld_next[wr_addr] = 1'b0;
            end
            if (cmd.stamp_we)
            begin
                stamp_vld_next[wr_addr] = 1'b1;
            end
            if (cmd.clr_stamp)
            begin
                stamp_vld_next[wr_addr] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_vld_reg <= '0;
            stamp_vld_reg <= '0;
            stats_hit_reg <= 1'b0;
            stamp_hit_reg <= 1'b0;
        end
        else
        begin
            stats_vld_reg <= stats_vld_next;
            stamp_vld_reg <= stamp_vld_next;
            if (rd_en)
            begin
                stats_hit_reg <= stats_vld_reg[rd_addr];
                stamp_hit_reg <= stamp_vld_reg[rd_addr];
            end
        end
    end

    // Invalid entries read as zero
    assign stats_rd = stats_hit_reg ? stats_raw_reg : '0;
    assign stamp_rd = stamp_hit_reg ? stamp_raw_reg : '0;

endmodule

@@ hw/rtl/lsm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Computes the truncated mean; depends on lsm_pkg.
module lsm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lsm_pkg::DATA_W-1:0] dividend,
    input  logic [lsm_pkg::DATA_W-1:0] divisor,
    output logic [lsm_pkg::DATA_W-1:0] quotient,
    output logic                       done
);
    import lsm_pkg::*;

    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_W:0]      trial;
    logic                 fits;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_next;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvs_reg};
        fits     = !trial[DATA_W];
        rem_next = fits ? trial[DATA_W-1:0] : {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
        quo_next = {quo_reg[DATA_W-2:0], fits};
    end

    // Datapath: load on start, shift while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/latency_stats_monitor.sv @@
// Top level of the latency statistics monitor: controller and fold logic.
// Instantiates lsm_mem and lsm_div; depends on lsm_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  request  | in_valid / in_ready  | op, instance_req, timestamp, delta_time
//  result   | out_valid / out_ready| accepted, call_count, total_time, last_time,
//           |                      | min_time, max_time, mean_time
//
// Stop and update requests pass through the divide step, where the mean comes
// from a 32-step iterative divider. Start, clear and out-of-range requests skip it.
// One request is in flight at a time; the result register lets the next request
// in while a result waits. Reset clears every record and stamp through valid
// bits, with no clearing pass. A stalled result holds the write-back step.
module latency_stats_monitor #(
    parameter int NUM_INSTANCES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lsm_pkg::OP_W-1:0]    op,
    input  logic [lsm_pkg::REQ_W-1:0]   instance_req,
    input  logic [lsm_pkg::TS_W-1:0]    timestamp,
    input  logic [lsm_pkg::DATA_W-1:0]  delta_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        accepted,
    output logic [lsm_pkg::DATA_W-1:0]  call_count,
    output logic [lsm_pkg::DATA_W-1:0]  total_time,
    output logic [lsm_pkg::DATA_W-1:0]  last_time,
    output logic [lsm_pkg::DATA_W-1:0]  min_time,
    output logic [lsm_pkg::DATA_W-1:0]  max_time,
    output logic [lsm_pkg::DATA_W-1:0]  mean_time
);
    import lsm_pkg::*;

    localparam int IDX_W = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;

    state_t            state_reg;
    state_t            state_next;

    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              in_range_reg;
    logic [DATA_W-1:0] ts_lo_reg;
    logic [DATA_W-1:0] delta_reg;
    logic [DATA_W-1:0] sample_reg;
    rec_t              work_reg;
    logic              wrap_reg;

    logic              out_valid_reg;
    logic              accepted_reg;
    rec_t              out_rec_reg;

    logic              in_range_now;
    logic              take_req;
    logic              out_free;
    logic              fold_op;
    logic              rd_en;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    mem_cmd_t          mem_cmd;

    rec_t              stats_rd;
    logic [DATA_W-1:0] stamp_rd;

    logic [DATA_W:0]   sum_wide;
    logic              fold_wrap;
    rec_t              fold_base;
    rec_t              fold_rec;

    assign in_range_now = instance_req < REQ_W'(NUM_INSTANCES);
    assign take_req     = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign fold_op      = in_range_reg && (op_reg == OP_STOP || op_reg == OP_UPDATE);

    lsm_mem #(
        .NUM_INSTANCES (NUM_INSTANCES),
        .IDX_W         (IDX_W)
    ) u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (rd_en),
        .rd_addr     (instance_req[IDX_W-1:0]),
        .stats_rd    (stats_rd),
        .stamp_rd    (stamp_rd),
        .wr_addr     (idx_reg),
        .cmd         (mem_cmd),
        .stats_wdata (work_reg),
        .stamp_wdata (ts_lo_reg)
    );

    lsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fold_rec.total_time),
        .divisor  (fold_rec.call_count),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Fold one sample into the record read from memory
    always_comb
    begin
        sum_wide  = {1'b0, stats_rd.total_time} + {1'b0, sample_reg};
        fold_wrap = (stats_rd.call_count == '1) || sum_wide[DATA_W];
        fold_base = fold_wrap ? '0 : stats_rd;

        fold_rec            = fold_base;
        fold_rec.call_count = fold_base.call_count + 1'b1;
        fold_rec.total_time = fold_wrap ? sample_reg : sum_wide[DATA_W-1:0];
        fold_rec.last_time  = sample_reg;
        if (fold_base.call_count == '0 || sample_reg < fold_base.min_time)
        begin
            fold_rec.min_time = sample_reg;
        end
        if (sample_reg > fold_base.max_time)
        begin
            fold_rec.max_time = sample_reg;
        end
        fold_rec.mean_time = '0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = fold_op ? ST_DIV : ST_WB;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        mem_cmd   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid && in_range_now;
            end
            ST_FOLD:
            begin
                div_start = fold_op;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    if (!in_range_reg)
                    begin
                        mem_cmd.clr_all = (op_reg == OP_CLEAR);
                    end
                    else
                    begin
                        case (op_reg)
                            OP_START:
                            begin
                                mem_cmd.stamp_we = 1'b1;
                            end
                            OP_STOP, OP_UPDATE:
                            begin
                                mem_cmd.stats_we  = 1'b1;
                                mem_cmd.clr_stamp = wrap_reg;
                            end
                            OP_CLEAR:
                            begin
                                mem_cmd.clr_stats = 1'b1;
                                mem_cmd.clr_stamp = 1'b1;
                            end
                            default:
                            begin
                                mem_cmd = '0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WB && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Capture the request
        if (take_req)
        begin
            op_reg       <= op_t'(op);
            idx_reg      <= instance_req[IDX_W-1:0];
            in_range_reg <= in_range_now;
            ts_lo_reg    <= timestamp[DATA_W-1:0];
            delta_reg    <= delta_time;
        end

        // Elapsed time wraps and keeps the low word only
        if (state_reg == ST_SAMPLE)
        begin
            sample_reg <= (op_reg == OP_STOP) ? (ts_lo_reg - stamp_rd) : delta_reg;
        end

        // Build the record to write back and return
        if (state_reg == ST_FOLD)
        begin
            wrap_reg <= fold_wrap;
            if (!in_range_reg || op_reg == OP_CLEAR)
            begin
                work_reg <= '0;
            end
            else if (op_reg == OP_START)
            begin
                work_reg <= stats_rd;
            end
            else
            begin
                work_reg <= fold_rec;
            end
        end

        if (state_reg == ST_DIV && div_done)
        begin
            work_reg.mean_time <= div_quo;
        end

        // Load the result register
        if (state_reg == ST_WB && out_free)
        begin
            accepted_reg <= in_range_reg;
            out_rec_reg  <= work_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign call_count = out_rec_reg.call_count;
    assign total_time = out_rec_reg.total_time;
    assign last_time  = out_rec_reg.last_time;
    assign min_time   = out_rec_reg.min_time;
    assign max_time   = out_rec_reg.max_time;
    assign mean_time  = out_rec_reg.mean_time;

endmodule

@@ verif/tb.sv @@
// Self-checking bench for latency_stats_monitor: directed and random requests
// are checked against a per-instance statistics predictor. Depends on lsm_pkg.
`timescale 1ns / 1ps

module tb;

    import lsm_pkg::*;

    localparam int NUM       = 32;
    localparam int RAND_REQS = 800;
    localparam int LIMIT     = 500000;
    localparam int MAX_GAP   = 8;

    // Expected or observed result of one request
    typedef struct packed {
        logic acc;
        rec_t rec;
    } outcome_t;

    // Predicts each record and checks results in request order
    class stats_scoreboard;
        rec_t        rec_tbl[NUM];
        logic [63:0] stamp_tbl[NUM];
        outcome_t    expected_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (rec_tbl[i])
            begin
                rec_tbl[i]   = '0;
                stamp_tbl[i] = '0;
            end
        endfunction

        // Zero the record first when the count saturates or the total would wrap
        function void fold_sample(int idx, logic [31:0] sample);
            logic [32:0] sum;
            sum = {1'b0, rec_tbl[idx].total_time} + {1'b0, sample};
            if (rec_tbl[idx].call_count == '1 || sum[32])
            begin
                rec_tbl[idx]   = '0;
                stamp_tbl[idx] = '0;
            end
            rec_tbl[idx].call_count = rec_tbl[idx].call_count + 1;
            rec_tbl[idx].last_time  = sample;
            rec_tbl[idx].total_time = rec_tbl[idx].total_time + sample;
            if (rec_tbl[idx].call_count == 1 || sample < rec_tbl[idx].min_time)
                rec_tbl[idx].min_time = sample;
            if (sample > rec_tbl[idx].max_time)
                rec_tbl[idx].max_time = sample;
            rec_tbl[idx].mean_time = rec_tbl[idx].total_time / rec_tbl[idx].call_count;
        endfunction

        function void note_request(op_t op_code, logic [7:0] inst, logic [63:0] ts,
                                   logic [31:0] delta);
            outcome_t    res;
            logic [63:0] elapsed;
            int          idx;
            res = '0;
            idx = int'(inst);
            if (idx >= NUM)
            begin
                // Out-of-range clear wipes every record; other ops do nothing
                if (op_code == OP_CLEAR)
                    clear_all();
            end
            else
            begin
                case (op_code)
                    OP_START:  stamp_tbl[idx] = ts;
                    OP_STOP:
                    begin
                        elapsed = ts - stamp_tbl[idx];
                        fold_sample(idx, elapsed[31:0]);
                    end
                    OP_UPDATE: fold_sample(idx, delta);
                    default:
                    begin
                        rec_tbl[idx]   = '0;
                        stamp_tbl[idx] = '0;
                    end
                endcase
                res.acc = 1'b1;
                res.rec = rec_tbl[idx];
            end
            expected_q.push_back(res);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %h, got %h", name, want, got);
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with no request pending: %h", got);
                return;
            end
            want = expected_q.pop_front();
            report_field("accepted", {31'b0, want.acc}, {31'b0, got.acc});
            report_field("call_count", want.rec.call_count, got.rec.call_count);
            report_field("total_time", want.rec.total_time, got.rec.total_time);
            report_field("last_time", want.rec.last_time, got.rec.last_time);
            report_field("min_time", want.rec.min_time, got.rec.min_time);
            report_field("max_time", want.rec.max_time, got.rec.max_time);
            report_field("mean_time", want.rec.mean_time, got.rec.mean_time);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     op;
    logic [REQ_W-1:0]    instance_req;
    logic [TS_W-1:0]     timestamp;
    logic [DATA_W-1:0]   delta_time;
    logic                out_valid;
    logic                out_ready;
    logic                accepted;
    logic [DATA_W-1:0]   call_count;
    logic [DATA_W-1:0]   total_time;
    logic [DATA_W-1:0]   last_time;
    logic [DATA_W-1:0]   min_time;
    logic [DATA_W-1:0]   max_time;
    logic [DATA_W-1:0]   mean_time;

    stats_scoreboard sb;
    bit              send_burst;
    bit              recv_burst;
    int              cycles;
    logic [63:0]     clock_us;
    logic [7:0]      last_started;

    latency_stats_monitor #(
        .NUM_INSTANCES (NUM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .instance_req (instance_req),
        .timestamp    (timestamp),
        .delta_time   (delta_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .call_count   (call_count),
        .total_time   (total_time),
        .last_time    (last_time),
        .min_time     (min_time),
        .max_time     (max_time),
        .mean_time    (mean_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("** latency_stats_monitor: FAILED **");
            $finish;
        end
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(op_t op_code, logic [7:0] inst, logic [63:0] ts,
                                logic [31:0] delta);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_code;
        instance_req <= inst;
        timestamp    <= ts;
        delta_time   <= delta;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op_code, inst, ts, delta);
    endtask

    // Hold off new requests until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Random request with a bias toward start/stop pairs on one instance
    task automatic send_random();
        int          pick;
        int          dpick;
        op_t         op_code;
        logic [7:0]  inst;
        logic [63:0] ts;
        logic [31:0] delta;
        pick  = $urandom_range(0, 99);
        dpick = $urandom_range(0, 99);
        clock_us = clock_us + $urandom_range(1, 3000);
        if ($urandom_range(0, 49) == 0)
            clock_us = clock_us + {30'b0, 2'($urandom_range(1, 3)), 32'($urandom)};
        ts = ($urandom_range(0, 9) == 0) ? {32'($urandom), 32'($urandom)} : clock_us;
        if (dpick < 60)
            delta = $urandom_range(0, 2000);
        else if (dpick < 85)
            delta = $urandom;
        else
            delta = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        inst = 8'($urandom_range(0, NUM - 1));
        if (pick < 5)
        begin
            op_code = op_t'($urandom_range(0, 2));
            inst    = 8'($urandom_range(NUM, 255));
        end
        else if (pick < 6)
        begin
            op_code = OP_CLEAR;
            inst    = 8'($urandom_range(NUM, 255));
        end
        else if (pick < 34)
        begin
            op_code      = OP_START;
            last_started = inst;
        end
        else if (pick < 64)
        begin
            op_code = OP_STOP;
            if ($urandom_range(0, 1) == 0)
                inst = last_started;
        end
        else if (pick < 92)
            op_code = OP_UPDATE;
        else
            op_code = OP_CLEAR;
        send_request(op_code, inst, ts, delta);
    endtask

    // Accept results after random stalls and check each one
    initial
    begin
        int       stall;
        int       seen;
        outcome_t got;
        seen = 0;
        wait (rst_n);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.acc = accepted;
            got.rec = '{call_count, total_time, last_time, min_time, max_time, mean_time};
            sb.check_result(got);
            seen++;
            if (seen % 64 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // Main sequence
    initial
    begin
        sb           = new();
        cycles       = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        clock_us     = 64'd1000;
        last_started = 8'd0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        op           = OP_START;
        instance_req = '0;
        timestamp    = '0;
        delta_time   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stop with no prior start measures against a zero stamp
        send_request(OP_STOP, 8'd0, 64'd5, 32'd0);
        // Stamp near the top of the range, stop after the 64-bit wrap
        send_request(OP_START, 8'd0, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF);
        send_request(OP_STOP, 8'd0, 64'h10, 32'd0);
        // Elapsed time wider than 32 bits is truncated
        send_request(OP_START, 8'd2, 64'h1_0000_0000, 32'd0);
        send_request(OP_STOP, 8'd2, 64'h3_1234_5678, 32'd0);
        // Zero sample, full-scale sample, then a total wrap that restarts the record
        send_request(OP_UPDATE, 8'd31, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_UPDATE, 8'd31, 64'd0, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 8'd31, 64'd0, 32'd1);
        // Min, max and mean
        send_request(OP_UPDATE, 8'd1, 64'd0, 32'd100);
        send_request(OP_UPDATE, 8'd1, 64'd0, 32'd50);
        send_request(OP_UPDATE, 8'd1, 64'd0, 32'd201);
        // Start leaves the record as it is
        send_request(OP_START, 8'd1, 64'hA5A5_5A5A_0F0F_F0F0, 32'd0);
        send_request(OP_CLEAR, 8'd1, 64'd0, 32'd0);
        send_request(OP_UPDATE, 8'd1, 64'd0, 32'd7);
        // Out-of-range start, stop and update change nothing
        send_request(OP_START, 8'd32, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_STOP, 8'd255, 64'h5555_5555_5555_5555, 32'd0);
        send_request(OP_UPDATE, 8'd32, 64'd0, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 8'd0, 64'd0, 32'd9);
        // Out-of-range clear wipes every record and stamp
        send_request(OP_CLEAR, 8'd255, 64'd0, 32'd0);
        send_request(OP_STOP, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_UPDATE, 8'd31, 64'd0, 32'hAAAA_AAAA);
        send_request(OP_UPDATE, 8'd31, 64'd0, 32'h5555_5555);
        drain_results();

        for (int n = 0; n < RAND_REQS; n++)
        begin
            if (n % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if (n == RAND_REQS / 2)
                drain_results();
            send_random();
        end
        in_valid <= 1'b0;

        // Let outstanding results come back, then settle
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("** latency_stats_monitor: PASSED **");
        else
            $display("** latency_stats_monitor: FAILED **");
        $finish;
    end

endmodule
